### design/odo_pkg.sv
// Shared types, widths and constants of the odometer accumulator.
package odo_pkg;

	// Field widths
	localparam int unsigned TOTAL_W = 30;
	localparam int unsigned TRIP_W  = 24;
	localparam int unsigned DIST_W  = 16;
	localparam int unsigned ELAP_W  = 8;
	localparam int unsigned ACC_W   = 32;
	localparam int unsigned TIMER_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	typedef logic [TOTAL_W-1:0]    total_t;
	typedef logic [TRIP_W-1:0]     trip_t;
	typedef logic [DIST_W-1:0]     dist_t;
	typedef logic [ELAP_W-1:0]     elap_t;
	typedef logic [ACC_W-1:0]      acc_t;
	typedef logic [TIMER_W-1:0]    timer_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// Register indexes of the configuration port
	localparam cfg_idx_t REG_INITIAL_TOTAL = 2'd0;
	localparam cfg_idx_t REG_INITIAL_TRIP  = 2'd1;
	localparam cfg_idx_t REG_UPDATE_PERIOD = 2'd2;

	// Scan constants
	localparam timer_t  SAVE_TIME_MS      = 16'd1000;
	localparam acc_t    MM_PER_METRE      = 32'd1000;
	localparam total_t  TOTAL_CAP         = 30'd999999000;
	localparam trip_t   TRIP_CAP          = 24'd9999999;
	localparam total_t  TOTAL_SEND_DELTA  = 30'd100;
	localparam trip_t   TRIP_SEND_DELTA   = 24'd100;
	localparam logic [3:0] METRES_PER_SAVE = 4'd10;
	localparam timer_t  UPDATE_PERIOD_RST = 16'd500;

endpackage

### design/odo_if.sv
// Channel interfaces: scan items in, results out, configuration writes.
interface odo_scan_if;
	logic                 valid;
	logic                 ready;
	odo_pkg::dist_t       add_distance_mm;
	odo_pkg::elap_t       elapsed_ms;

	modport source (output valid, output add_distance_mm, output elapsed_ms, input ready);
	modport sink   (input valid, input add_distance_mm, input elapsed_ms, output ready);
endinterface

interface odo_result_if;
	logic                 valid;
	logic                 ready;
	odo_pkg::total_t      total_m;
	odo_pkg::trip_t       trip_m;
	logic                 save_request;
	logic                 send_total;
	logic                 send_trip;

	modport source (output valid, output total_m, output trip_m, output save_request,
		output send_total, output send_trip, input ready);
	modport sink   (input valid, input total_m, input trip_m, input save_request,
		input send_total, input send_trip, output ready);
endinterface

interface odo_cfg_if;
	logic                 valid;
	logic                 ready;
	odo_pkg::cfg_idx_t    index;
	odo_pkg::cfg_data_t   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### design/odometer_accumulator_unit.sv
// Odometer accumulator top level: scan input register, scan logic, result register.
//
// Usage:
//   scan   : one item per transfer (add_distance_mm, elapsed_ms).
//   result : one item per scan transfer (total_m, trip_m, save_request,
//            send_total, send_trip), in scan order.
//   cfg    : register writes (index 0 initial total, 1 initial trip,
//            2 update period). Always ready. Writing an initial value
//            loads the matching odometer at once. Write only while idle.
// Timing:
//   A scan item is captured in the input register; when the result register
//   is empty or being taken, the scan logic updates all state and loads it.
//   Throughput is one item per cycle while the receiver takes every result;
//   the state update loop closes through one add/saturate and compare chain.
// Stall:
//   While result is held by the receiver, the item in the input register
//   waits and the scan side stays ready until that register is full.
// Reset:
//   arst_n clears both valid flags, timers, accumulator and odometers;
//   the update period returns to 500 ms.
module odometer_accumulator_unit (
	input  logic        clk,
	input  logic        arst_n,
	odo_scan_if.sink    scan,
	odo_result_if.source result,
	odo_cfg_if.sink     cfg
);

	// Input register
	logic                valid_s1;
	odo_pkg::dist_t      add_s1;
	odo_pkg::elap_t      elap_s1;

	// Scan state
	odo_pkg::acc_t       dist_q;
	odo_pkg::timer_t     save_timer_q;
	odo_pkg::timer_t     update_timer_q;
	odo_pkg::timer_t     period_q;
	odo_pkg::total_t     total_q;
	odo_pkg::trip_t      trip_q;
	odo_pkg::total_t     last_total_q;
	odo_pkg::trip_t      last_trip_q;
	logic [3:0]          mod_ten_q;
	logic                save_pending_q;
	logic                alt_total_q;

	// Result register
	logic                out_valid_q;
	odo_pkg::total_t     out_total_q;
	odo_pkg::trip_t      out_trip_q;
	logic                out_save_q;
	logic                out_send_total_q;
	logic                out_send_trip_q;

	logic                advance;
	logic                scan_xfer;
	logic                cfg_xfer;

	logic [odo_pkg::ACC_W:0]   acc_sum;
	odo_pkg::acc_t             acc_sat;
	logic [odo_pkg::TIMER_W:0] save_sum;
	logic [odo_pkg::TIMER_W:0] upd_sum;
	odo_pkg::timer_t           save_sat;
	odo_pkg::timer_t           upd_sat;
	logic                      save_fire;
	logic                      metre;
	logic                      total_inc;
	logic                      trip_inc;
	odo_pkg::total_t           total_nx;
	odo_pkg::trip_t            trip_nx;
	logic [3:0]                mod_inc;
	logic                      mod_wrap;
	logic                      total_grow;
	logic                      trip_grow;
	logic                      period_hit;

	// Handshakes
	assign advance   = valid_s1 && (!out_valid_q || result.ready);
	assign scan.ready = !valid_s1 || advance;
	assign scan_xfer = scan.valid && scan.ready;
	assign cfg.ready = 1'b1;
	assign cfg_xfer  = cfg.valid;

	// Accumulate distance and time with saturation
	always_comb begin
		acc_sum  = {1'b0, dist_q} + (odo_pkg::ACC_W + 1)'(add_s1);
		acc_sat  = acc_sum[odo_pkg::ACC_W] ? '1 : acc_sum[odo_pkg::ACC_W-1:0];
		save_sum = {1'b0, save_timer_q} + (odo_pkg::TIMER_W + 1)'(elap_s1);
		upd_sum  = {1'b0, update_timer_q} + (odo_pkg::TIMER_W + 1)'(elap_s1);
		save_sat = save_sum[odo_pkg::TIMER_W] ? '1 : save_sum[odo_pkg::TIMER_W-1:0];
		upd_sat  = upd_sum[odo_pkg::TIMER_W] ? '1 : upd_sum[odo_pkg::TIMER_W-1:0];
	end

	// Scan decisions
	always_comb begin
		save_fire  = (save_sat >= odo_pkg::SAVE_TIME_MS) && save_pending_q;
		metre      = acc_sat >= odo_pkg::MM_PER_METRE;
		total_inc  = metre && (total_q < odo_pkg::TOTAL_CAP);
		trip_inc   = metre && (trip_q < odo_pkg::TRIP_CAP);
		total_nx   = total_q + odo_pkg::TOTAL_W'(total_inc);
		trip_nx    = trip_q + odo_pkg::TRIP_W'(trip_inc);
		mod_inc    = mod_ten_q + 4'd1;
		mod_wrap   = mod_inc >= odo_pkg::METRES_PER_SAVE;
		// differences wrap at the odometer width
		total_grow = (total_nx - last_total_q) > odo_pkg::TOTAL_SEND_DELTA;
		trip_grow  = (trip_nx - last_trip_q) > odo_pkg::TRIP_SEND_DELTA;
		period_hit = upd_sat >= period_q;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_xfer) begin
			add_s1  <= scan.add_distance_mm;
			elap_s1 <= scan.elapsed_ms;
		end
	end

	// Scan state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q         <= '0;
			save_timer_q   <= '0;
			update_timer_q <= '0;
			period_q       <= odo_pkg::UPDATE_PERIOD_RST;
			total_q        <= '0;
			trip_q         <= '0;
			last_total_q   <= '0;
			last_trip_q    <= '0;
			mod_ten_q      <= '0;
			save_pending_q <= 1'b0;
			alt_total_q    <= 1'b0;
		end else if (cfg_xfer) begin
			case (cfg.index)
				odo_pkg::REG_INITIAL_TOTAL: total_q  <= cfg.data[odo_pkg::TOTAL_W-1:0];
				odo_pkg::REG_INITIAL_TRIP:  trip_q   <= cfg.data[odo_pkg::TRIP_W-1:0];
				odo_pkg::REG_UPDATE_PERIOD: period_q <= cfg.data[odo_pkg::TIMER_W-1:0];
				default: ;
			endcase
		end else if (advance) begin
			dist_q         <= metre ? acc_sat - odo_pkg::MM_PER_METRE : acc_sat;
			save_timer_q   <= save_fire ? '0 : save_sat;
			update_timer_q <= period_hit ? '0 : upd_sat;
			total_q        <= total_nx;
			trip_q         <= trip_nx;
			if (total_grow) begin
				last_total_q <= total_nx;
			end
			if (trip_grow) begin
				last_trip_q <= trip_nx;
			end
			if (metre) begin
				mod_ten_q <= mod_wrap ? 4'd0 : mod_inc;
			end
			// a new tenth metre wins over the clear from a save
			if (metre && mod_wrap) begin
				save_pending_q <= 1'b1;
			end else if (save_fire) begin
				save_pending_q <= 1'b0;
			end
			if (period_hit) begin
				alt_total_q <= !alt_total_q;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_total_q      <= total_nx;
			out_trip_q       <= trip_nx;
			out_save_q       <= save_fire;
			out_send_total_q <= total_grow || (period_hit && alt_total_q);
			out_send_trip_q  <= trip_grow || (period_hit && !alt_total_q);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.total_m      = out_total_q;
	assign result.trip_m       = out_trip_q;
	assign result.save_request = out_save_q;
	assign result.send_total   = out_send_total_q;
	assign result.send_trip    = out_send_trip_q;

endmodule

### design/odo_checker.sv
// Port-level checker for the odometer accumulator, bound to the top level.
module odo_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            scan_valid,
	input logic            scan_ready,
	input logic            res_valid,
	input logic            res_ready,
	input odo_pkg::total_t res_total_m,
	input odo_pkg::trip_t  res_trip_m
);

	// No result is shown while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	// A held result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped without transfer");

	// A held result keeps its odometer values
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_total_m) && $stable(res_trip_m))
		else $error("result payload changed while stalled");

	// With the receiver ready, a scan transfer passes the input register and the result register, then shows its result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_valid && scan_ready && res_ready) ##1 res_ready |=> res_valid)
		else $error("result missing after scan transfer");

endmodule

bind odometer_accumulator_unit odo_checker u_odo_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.scan_valid  (scan.valid),
	.scan_ready  (scan.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_total_m (result.total_m),
	.res_trip_m  (result.trip_m)
);

### sim/tb_top.sv
// Self-checking testbench for the odometer accumulator: scan table, random scans, register phases.
module tb_top;

	localparam int unsigned IDLE_PCT      = 27;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned STALL_LIMIT   = 4000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned PHASE_ITEMS   = 270;
	localparam int unsigned BURST_ITEMS   = 120;
	localparam int unsigned DIR_ROWS      = 22;

	// One odometer reading as it leaves the block
	typedef struct packed {
		odo_pkg::total_t total;
		odo_pkg::trip_t  trip;
		logic            save_request;
		logic            send_total;
		logic            send_trip;
	} reading_t;

	// Row of the scan table; typed rows carry their reading, others use the odometer model
	typedef struct packed {
		odo_pkg::dist_t dist_mm;
		odo_pkg::elap_t elapsed;
		logic           typed;
		reading_t       reading;
	} scan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	odo_scan_if   scan_ch ();
	odo_result_if res_ch ();
	odo_cfg_if    cfg_ch ();

	odometer_accumulator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.scan(scan_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	// Clock: period of 4
	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// Odometer model state
	odo_pkg::acc_t   mm_acc;
	odo_pkg::timer_t save_tmr;
	odo_pkg::timer_t upd_tmr;
	odo_pkg::timer_t period;
	odo_pkg::total_t odo_total;
	odo_pkg::total_t sent_total;
	odo_pkg::trip_t  odo_trip;
	odo_pkg::trip_t  sent_trip;
	logic [3:0]      metre_cnt;
	logic            save_pend;
	logic            total_turn;

	reading_t    reading_q [$];
	int unsigned err_cnt = 0;
	int unsigned tx_idle_pct = IDLE_PCT;
	int unsigned rx_idle_pct = IDLE_PCT;
	logic [7:0]  hold_token = '0;
	logic [7:0]  hold_seen = '0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;

	// Scan table, all under the reset configuration (update period 500 ms)
	scan_row_t dir_rows [DIR_ROWS] = '{
		'{16'd0,     8'd0,   1'b1, '{30'd0, 24'd0, 1'b0, 1'b0, 1'b0}},
		'{16'd999,   8'd0,   1'b1, '{30'd0, 24'd0, 1'b0, 1'b0, 1'b0}},
		'{16'd1,     8'd0,   1'b1, '{30'd1, 24'd1, 1'b0, 1'b0, 1'b0}},
		'{16'd0,     8'd255, 1'b1, '{30'd1, 24'd1, 1'b0, 1'b0, 1'b0}},
		'{16'd0,     8'd245, 1'b1, '{30'd1, 24'd1, 1'b0, 1'b0, 1'b1}},
		'{16'd65535, 8'd0,   1'b1, '{30'd2, 24'd2, 1'b0, 1'b0, 1'b0}},
		'{16'd0,     8'd0,   1'b0, '0},
		'{16'd0,     8'd0,   1'b0, '0},
		'{16'd0,     8'd0,   1'b0, '0},
		'{16'd0,     8'd0,   1'b0, '0},
		'{16'd0,     8'd0,   1'b0, '0},
		'{16'd0,     8'd0,   1'b0, '0},
		'{16'd0,     8'd0,   1'b0, '0},
		'{16'd0,     8'd0,   1'b0, '0},
		'{16'd0,     8'd255, 1'b0, '0},
		'{16'd0,     8'd255, 1'b0, '0},
		'{16'd65535, 8'd255, 1'b0, '0},
		'{16'd0,     8'd255, 1'b0, '0},
		'{16'd1000,  8'd1,   1'b0, '0},
		'{16'd65535, 8'd0,   1'b0, '0},
		'{16'd0,     8'd0,   1'b0, '0},
		'{16'd12345, 8'd128, 1'b0, '0}
	};

	function automatic void reset_odometer();
		mm_acc     = '0;
		save_tmr   = '0;
		upd_tmr    = '0;
		period     = odo_pkg::UPDATE_PERIOD_RST;
		odo_total  = '0;
		odo_trip   = '0;
		sent_total = '0;
		sent_trip  = '0;
		metre_cnt  = '0;
		save_pend  = 1'b0;
		total_turn = 1'b0;
	endfunction

	// Loading an initial value also loads the odometer itself
	function automatic void load_register(odo_pkg::cfg_idx_t idx, odo_pkg::cfg_data_t val);
		case (idx)
			odo_pkg::REG_INITIAL_TOTAL: odo_total = val[odo_pkg::TOTAL_W-1:0];
			odo_pkg::REG_INITIAL_TRIP:  odo_trip = val[odo_pkg::TRIP_W-1:0];
			odo_pkg::REG_UPDATE_PERIOD: period = val[odo_pkg::TIMER_W-1:0];
			default: ;
		endcase
	endfunction

	// One scan: accumulate, save check, one metre at most, growth sends, forced send
	function automatic reading_t scan_odometer(odo_pkg::dist_t d, odo_pkg::elap_t e);
		logic [odo_pkg::ACC_W:0]   acc_sum;
		logic [odo_pkg::TIMER_W:0] save_sum;
		logic [odo_pkg::TIMER_W:0] upd_sum;
		odo_pkg::total_t           total_grow;
		odo_pkg::trip_t            trip_grow;
		reading_t                  r;
		r = '0;
		acc_sum  = {1'b0, mm_acc} + (odo_pkg::ACC_W + 1)'(d);
		save_sum = {1'b0, save_tmr} + (odo_pkg::TIMER_W + 1)'(e);
		upd_sum  = {1'b0, upd_tmr} + (odo_pkg::TIMER_W + 1)'(e);
		mm_acc   = acc_sum[odo_pkg::ACC_W] ? '1 : acc_sum[odo_pkg::ACC_W-1:0];
		save_tmr = save_sum[odo_pkg::TIMER_W] ? '1 : save_sum[odo_pkg::TIMER_W-1:0];
		upd_tmr  = upd_sum[odo_pkg::TIMER_W] ? '1 : upd_sum[odo_pkg::TIMER_W-1:0];

		if (save_tmr >= odo_pkg::SAVE_TIME_MS && save_pend) begin
			r.save_request = 1'b1;
			save_pend = 1'b0;
			save_tmr = '0;
		end

		if (mm_acc >= odo_pkg::MM_PER_METRE) begin
			if (odo_total < odo_pkg::TOTAL_CAP)
				odo_total = odo_total + odo_pkg::total_t'(1);
			if (odo_trip < odo_pkg::TRIP_CAP)
				odo_trip = odo_trip + odo_pkg::trip_t'(1);
			mm_acc = mm_acc - odo_pkg::MM_PER_METRE;
			metre_cnt = metre_cnt + 4'd1;
			if (metre_cnt >= odo_pkg::METRES_PER_SAVE) begin
				metre_cnt = '0;
				save_pend = 1'b1;
			end
		end

		// growth wraps at the odometer width
		total_grow = odo_total - sent_total;
		trip_grow  = odo_trip - sent_trip;
		if (total_grow > odo_pkg::TOTAL_SEND_DELTA) begin
			sent_total = odo_total;
			r.send_total = 1'b1;
		end
		if (trip_grow > odo_pkg::TRIP_SEND_DELTA) begin
			sent_trip = odo_trip;
			r.send_trip = 1'b1;
		end

		if (upd_tmr >= period) begin
			upd_tmr = '0;
			if (total_turn)
				r.send_total = 1'b1;
			else
				r.send_trip = 1'b1;
			total_turn = !total_turn;
		end

		r.total = odo_total;
		r.trip  = odo_trip;
		return r;
	endfunction

	function automatic void check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			err_cnt++;
		end
	endfunction

	// Result checker
	always @(posedge clk) begin : result_check
		reading_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (reading_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got total %0d trip %0d",
					$time, res_ch.total_m, res_ch.trip_m);
				err_cnt++;
			end else begin
				want = reading_q.pop_front();
				check_field("total_m", want.total, res_ch.total_m);
				check_field("trip_m", want.trip, res_ch.trip_m);
				check_field("save_request", want.save_request, res_ch.save_request);
				check_field("send_total", want.send_total, res_ch.send_total);
				check_field("send_trip", want.send_trip, res_ch.send_trip);
			end
		end
	end

	// Result receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			res_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((scan_ch.valid && scan_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one scan item; valid stays high after the transfer
	task automatic offer_scan(odo_pkg::dist_t d, odo_pkg::elap_t e, logic typed,
		reading_t typed_val);
		reading_t predicted;
		if ($urandom_range(99) < tx_idle_pct) begin
			scan_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		scan_ch.valid <= 1'b1;
		scan_ch.add_distance_mm <= d;
		scan_ch.elapsed_ms <= e;
		do @(posedge clk); while (!scan_ch.ready);
		predicted = scan_odometer(d, e);
		reading_q.push_back(typed ? typed_val : predicted);
	endtask

	// Mostly small distances and short times, with full range and extremes mixed in
	task automatic pick_scan(output odo_pkg::dist_t d, output odo_pkg::elap_t e);
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 55)
			d = odo_pkg::dist_t'($urandom_range(1500));
		else if (sel < 80)
			d = odo_pkg::dist_t'($urandom);
		else if (sel < 90)
			d = '0;
		else
			d = '1;
		sel = $urandom_range(99);
		if (sel < 50)
			e = odo_pkg::elap_t'($urandom_range(20));
		else if (sel < 80)
			e = odo_pkg::elap_t'($urandom);
		else if (sel < 90)
			e = '0;
		else
			e = '1;
	endtask

	task automatic run_random(int unsigned count);
		odo_pkg::dist_t d;
		odo_pkg::elap_t e;
		for (int unsigned i = 0; i < count; i++) begin
			pick_scan(d, e);
			offer_scan(d, e, 1'b0, '0);
		end
	endtask

	// Stop offering and wait until every reading has come back
	task automatic drain_results();
		scan_ch.valid <= 1'b0;
		while (reading_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers back to back
	task automatic configure(odo_pkg::total_t tot, odo_pkg::trip_t trp, odo_pkg::timer_t per);
		odo_pkg::cfg_idx_t  idx [3];
		odo_pkg::cfg_data_t val [3];
		idx = '{odo_pkg::REG_INITIAL_TOTAL, odo_pkg::REG_INITIAL_TRIP,
			odo_pkg::REG_UPDATE_PERIOD};
		val = '{odo_pkg::cfg_data_t'(tot), odo_pkg::cfg_data_t'(trp),
			odo_pkg::cfg_data_t'(per)};
		cfg_ch.valid <= 1'b1;
		for (int i = 0; i < 3; i++) begin
			cfg_ch.index <= idx[i];
			cfg_ch.data <= val[i];
			do @(posedge clk); while (!cfg_ch.ready);
			load_register(idx[i], val[i]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Stimulus
	initial begin : stimulus
		odo_pkg::dist_t d;
		odo_pkg::elap_t e;
		scan_ch.valid = 1'b0;
		scan_ch.add_distance_mm = '0;
		scan_ch.elapsed_ms = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = odo_pkg::REG_INITIAL_TOTAL;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		reset_odometer();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// scan table under reset configuration
		for (int i = 0; i < DIR_ROWS; i++)
			offer_scan(dir_rows[i].dist_mm, dir_rows[i].elapsed, dir_rows[i].typed,
				dir_rows[i].reading);

		// random scans; receiver holds off while the sender keeps offering,
		// later the sender pauses until everything is back
		for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
			if (i == 40)
				hold_token <= hold_token + 8'd1;
			if (i == 150)
				drain_results();
			pick_scan(d, e);
			offer_scan(d, e, 1'b0, '0);
		end
		drain_results();

		// just below the caps, shortest non-zero period
		configure(odo_pkg::total_t'(odo_pkg::TOTAL_CAP - 10),
			odo_pkg::trip_t'(odo_pkg::TRIP_CAP - 10), 16'd1);
		run_random(PHASE_ITEMS);
		drain_results();

		// loaded above the caps, zero period
		configure('1, '1, '0);
		run_random(PHASE_ITEMS);
		drain_results();

		// zero odometers, longest period, no idling on either side
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		configure('0, '0, '1);
		run_random(PHASE_ITEMS);
		drain_results();
		tx_idle_pct = IDLE_PCT;
		rx_idle_pct <= IDLE_PCT;

		// random settings
		configure(odo_pkg::total_t'($urandom_range(odo_pkg::TOTAL_CAP)),
			odo_pkg::trip_t'($urandom_range(odo_pkg::TRIP_CAP)),
			odo_pkg::timer_t'($urandom_range(1, 16'hFFFF)));
		run_random(PHASE_ITEMS);
		drain_results();

		// full-distance burst: one metre per scan carries both odometers
		// onto their caps and holds them there
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		configure(odo_pkg::total_t'(odo_pkg::TOTAL_CAP - 60),
			odo_pkg::trip_t'(odo_pkg::TRIP_CAP - 60), odo_pkg::UPDATE_PERIOD_RST);
		for (int unsigned i = 0; i < BURST_ITEMS; i++)
			offer_scan('1, odo_pkg::elap_t'($urandom), 1'b0, '0);
		tx_idle_pct = IDLE_PCT;
		rx_idle_pct <= IDLE_PCT;
		run_random(60);
		drain_results();

		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
